FILE: rtl/ropr_pkg.sv
// Shared types and constants for the rotated offset pair range unit.
`default_nettype none
package ropr_pkg;
  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam logic [0:0] OP_ORIGIN = 1'b0;
  localparam logic [0:0] OP_END    = 1'b1;

  // Micro-operations of the shared datapath.
  typedef enum logic [3:0] {
    UOP_LOAD  = 4'd0,
    UOP_DOT   = 4'd1,
    UOP_KSC   = 4'd2,
    UOP_CROSS = 4'd3,
    UOP_TERMS = 4'd4,
    UOP_SUM   = 4'd5,
    UOP_SQR   = 4'd6,
    UOP_ROOT  = 4'd7,
    UOP_HOLD  = 4'd8
  } uop_t;

  typedef struct packed {
    uop_t       uop;
    logic [1:0] axis;
    logic [1:0] sub;
  } ropr_cmd_t;

  typedef struct packed {
    logic root_done;
    logic is_end;
  } ropr_stat_t;
endpackage
`default_nettype wire

FILE: rtl/rotated_offset_pair_range_unit.sv
// Top level of the rotated offset pair range unit.
`default_nettype none
// Each word carries a body pose and a node offset; the unit rotates the offset by the
// quaternion, adds the position and returns the world node point. An origin word stores
// that point, an end word also returns the distance to it. The products of the dot, scale
// and cross steps share one multiplier and the square root yields one bit per cycle, so
// words are taken one at a time: a new word is accepted only after the previous result
// has moved into the result register, which waits while that register is still full.
// The result register lets the next word enter while a result waits.
module rotated_offset_pair_range_unit #(
  parameter int unsigned POSITION_BITS = ropr_pkg::POSITION_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w, offset_x, offset_y, offset_z
  input  wire logic [319:0] s_axis_tdata,
  // operation
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // node_x, node_y, node_z, distance
  output logic [127:0]      m_axis_tdata,
  // range_valid
  output logic              m_axis_tuser
);
  import ropr_pkg::*;

  ropr_cmd_t  cmd;
  ropr_stat_t stat;
  logic       busy, out_load, in_fire, out_free;
  logic [31:0] nx, ny, nz, span;
  logic        rv;

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  ropr_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_free, .stat, .cmd, .busy, .out_load
  );

  ropr_dp #(.POSITION_BITS(POSITION_BITS)) u_dp (
    .clk, .rst, .in_item({s_axis_tdata, s_axis_tuser}), .cmd, .stat,
    .node_x(nx), .node_y(ny), .node_z(nz), .range_valid(rv), .distance(span)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {span, nz, ny, nx};
      m_axis_tuser <= rv;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_fire) else $error("word accepted while busy");
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free) else $error("result overwritten");
  a_origin_no_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[127:96] == 32'd0)
    else $error("origin word carries a distance");
`endif
endmodule
`default_nettype wire

FILE: rtl/ropr_ctrl.sv
// Sequencer for the rotated offset pair range unit.
`default_nettype none
module ropr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic              out_free,
  input  ropr_pkg::ropr_stat_t   stat,
  output ropr_pkg::ropr_cmd_t    cmd,
  output logic                   busy,
  output logic                   out_load
);
  import ropr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DOT   = 7'b0000010,
    S_KSC   = 7'b0000100,
    S_ROT   = 7'b0001000,
    S_SQR   = 7'b0010000,
    S_ROOT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] axis, axis_next;
  logic [1:0] sub, sub_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
      sub   <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      sub   <= sub_next;
    end
  end

  always_comb begin
    state_next   = state;
    axis_next    = axis;
    sub_next     = sub;
    cmd.uop      = UOP_HOLD;
    cmd.axis     = axis;
    cmd.sub      = sub;
    out_load     = 1'b0;
    busy         = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.uop    = UOP_LOAD;
          state_next = S_DOT;
          axis_next  = 2'd0;
          sub_next   = 2'd0;
        end
      end
      // One product per cycle into the dot product accumulator.
      S_DOT: begin
        cmd.uop = UOP_DOT;
        if (axis == 2'd2) begin
          axis_next = 2'd0; state_next = S_KSC;
        end else axis_next = axis + 2'd1;
      end
      // Product 0 is s*s, 1..3 subtract u.u.
      S_KSC: begin
        cmd.uop = UOP_KSC;
        if (sub == 2'd3) begin
          sub_next = 2'd0; state_next = S_ROT;
        end else sub_next = sub + 2'd1;
      end
      // Per axis: two cross products, then three terms, then the sum.
      S_ROT: begin
        if (sub <= 2'd1) cmd.uop = UOP_CROSS;
        else if (sub == 2'd2) cmd.uop = UOP_TERMS;
        else cmd.uop = UOP_SUM;
        sub_next = sub + 2'd1;
        if (sub == 2'd3) begin
          if (axis == 2'd2) begin
            axis_next = 2'd0;
            state_next = stat.is_end ? S_SQR : S_OUT;
          end else axis_next = axis + 2'd1;
        end
      end
      S_SQR: begin
        cmd.uop = UOP_SQR;
        if (axis == 2'd2) begin
          axis_next = 2'd0; state_next = S_ROOT;
        end else axis_next = axis + 2'd1;
      end
      S_ROOT: begin
        cmd.uop = UOP_ROOT;
        if (stat.root_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/ropr_dp.sv
// Datapath of the rotated offset pair range unit: shared multiplier, accumulators and root.
`default_nettype none
module ropr_dp #(
  parameter int unsigned POSITION_BITS = ropr_pkg::POSITION_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [320:0]     in_item,
  input  ropr_pkg::ropr_cmd_t   cmd,
  output ropr_pkg::ropr_stat_t  stat,
  output logic [31:0]           node_x,
  output logic [31:0]           node_y,
  output logic [31:0]           node_z,
  output logic                  range_valid,
  output logic [31:0]           distance
);
  import ropr_pkg::*;

  localparam int unsigned PB = POSITION_BITS;

  logic               op;
  logic signed [31:0] p [3];
  logic signed [31:0] u [3];
  logic signed [31:0] v [3];
  logic signed [31:0] s;
  logic signed [64:0] acc;
  logic signed [33:0] d;
  logic signed [33:0] k;
  logic signed [33:0] c;
  logic signed [PB-1:0] w [3];
  logic signed [PB-1:0] org [3];
  logic [63:0]        sq;
  logic [63:0]        rem;
  logic [63:0]        root;
  logic [5:0]         rstep;
  logic signed [65:0] t;

  function automatic logic signed [31:0] clampq(input logic [31:0] x);
    logic signed [31:0] y;
    y = signed'(x);
    if (y > 32'sd1073741824) return 32'sd1073741824;
    if (y < -32'sd1073741824) return -32'sd1073741824;
    return y;
  endfunction

  // Signed multiply of two narrow operands, one product per cycle.
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  assign prod = ma * mb;

  logic [1:0] ax1, ax2;
  always_comb begin
    ax1 = (cmd.axis == 2'd2) ? 2'd0 : cmd.axis + 2'd1;
    ax2 = (cmd.axis == 2'd0) ? 2'd2 : cmd.axis - 2'd1;
    ma = '0; mb = '0;
    case (cmd.uop)
      UOP_DOT: begin ma = 34'(u[cmd.axis]); mb = 34'(v[cmd.axis]); end
      UOP_KSC: begin
        if (cmd.sub == 2'd0) begin ma = 34'(s); mb = 34'(s); end
        else begin ma = 34'(u[cmd.sub - 2'd1]); mb = 34'(u[cmd.sub - 2'd1]); end
      end
      UOP_CROSS: begin
        if (cmd.sub == 2'd0) begin ma = 34'(u[ax1]); mb = 34'(v[ax2]); end
        else begin ma = 34'(u[ax2]); mb = 34'(v[ax1]); end
      end
      default: ;
    endcase
  end

  // Terms of the rotation: d*u, k*v, c*s, each up to 34x32 bits.
  logic signed [65:0] td, tk, tc;
  assign td = d * u[cmd.axis];
  assign tk = k * v[cmd.axis];
  assign tc = c * s;
  logic signed [65:0] rterm;
  assign rterm = ((td >>> 30) <<< 1) + (tk >>> 30) + (tc >>> 29);

  logic signed [65:0] tsum;
  logic signed [PB-1:0] wsat;
  logic signed [65:0] hi_l, lo_l;
  assign tsum = t + 66'(p[cmd.axis]);
  assign hi_l = 66'((67'sd1 <<< (PB - 1)) - 67'sd1);
  assign lo_l = -hi_l - 66'sd1;
  assign wsat = (tsum > hi_l) ? hi_l[PB-1:0] :
                (tsum < lo_l) ? lo_l[PB-1:0] : tsum[PB-1:0];

  logic signed [PB:0] dlt;
  logic [64:0]        mag;
  logic [63:0]        msq;
  logic [64:0]        sq_sum;
  assign dlt = (PB+1)'(w[cmd.axis]) - (PB+1)'(org[cmd.axis]);
  assign mag = 65'(unsigned'(dlt[PB] ? -dlt : dlt));
  assign msq = 64'(mag[31:0]) * 64'(mag[31:0]);
  assign sq_sum = 65'(sq) + 65'(msq);

  // One root bit per step in restoring form, from the top bit pair down to bit 0.
  logic [5:0]  rm1;
  logic [63:0] rbit;
  logic [63:0] trial;
  assign rm1   = rstep - 6'd1;
  assign rbit  = 64'd1 << {rm1[4:0], 1'b0};
  assign trial = root + rbit;

  function automatic logic [31:0] s32(input logic signed [PB-1:0] x);
    logic signed [63:0] xe;
    xe = 64'(x);
    if (xe > 64'sh7fffffff) return 32'h7fffffff;
    if (xe < -64'sh80000000) return 32'h80000000;
    return xe[31:0];
  endfunction

  assign node_x      = s32(w[0]);
  assign node_y      = s32(w[1]);
  assign node_z      = s32(w[2]);
  assign range_valid = op;
  assign distance    = op ? root[31:0] : 32'd0;
  assign stat.root_done = (rstep == 6'd0);
  assign stat.is_end    = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) org[i] <= '0;
      rstep <= '0;
    end else begin
      case (cmd.uop)
        UOP_LOAD: begin
          op <= in_item[0];
          for (int i = 0; i < 3; i++) begin
            p[i] <= in_item[1 + 32*i +: 32];
            u[i] <= clampq(in_item[97 + 32*i +: 32]);
            v[i] <= in_item[225 + 32*i +: 32];
          end
          s   <= clampq(in_item[193 +: 32]);
          acc <= '0;
          sq  <= '0;
        end
        UOP_DOT: begin
          if (cmd.axis == 2'd2) begin
            d   <= 34'((acc + 65'(prod)) >>> 30);
            acc <= '0;
          end else acc <= acc + 65'(prod);
        end
        UOP_KSC: begin
          if (cmd.sub == 2'd0) acc <= 65'(prod);
          else if (cmd.sub == 2'd3) begin
            k   <= 34'((acc - 65'(prod)) >>> 30);
            acc <= '0;
          end else acc <= acc - 65'(prod);
        end
        UOP_CROSS: begin
          if (cmd.sub == 2'd0) acc <= 65'(prod);
          else c <= 34'((acc - 65'(prod)) >>> 30);
        end
        UOP_TERMS: t <= rterm;
        UOP_SUM: begin
          w[cmd.axis] <= wsat;
          if (!op) org[cmd.axis] <= wsat;
        end
        UOP_SQR: begin
          if (mag > 65'h0ffffffff || sq_sum[64]) sq <= '1;
          else sq <= sq_sum[63:0];
          if (cmd.axis == 2'd2) begin
            rstep <= 6'd33;
            root  <= '0;
          end
        end
        UOP_ROOT: begin
          // The first cycle takes the finished sum of squares, then 32 bit steps follow.
          if (rstep == 6'd33) begin
            rstep <= 6'd32;
            rem   <= sq;
          end else if (rstep != 6'd0) begin
            if (rem >= trial) begin
              rem  <= rem - trial;
              root <= (root >> 1) + rbit;
            end else root <= root >> 1;
            rstep <= rstep - 6'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
